FILE: hdl/stsw_pkg.sv
`default_nettype none

package stsw_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_EDGE   = 2'd1,
		KIND_REMOTE = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LIMIT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK         = 3'd5;

	localparam logic [7:0]  RST_SAMPLE_PERIOD = 8'd10;
	localparam logic [7:0]  RST_SAMPLE_COUNT  = 8'd20;
	localparam logic [15:0] RST_HOLDOFF       = 16'd300;
	localparam logic [7:0]  RST_PRESS_LIMIT   = 8'd12;
	localparam logic [15:0] RST_WINDOW        = 16'd10000;
	localparam logic [15:0] RST_BLOCK         = 16'd10000;

	typedef struct packed {
		logic [7:0]  sample_period_ms;
		logic [7:0]  sample_count;
		logic [15:0] holdoff_ms;
		logic [7:0]  press_limit;
		logic [15:0] window_ms;
		logic [15:0] block_ms;
	} cfg_t;

	typedef struct packed {
		logic relay_on;
		logic locked;
		logic report_request;
		logic sampling;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/sampled_toggle_switch_with_lockout.sv
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    kind, switch_level, remote_value
// output    out_valid/out_ready  relay_on, locked, report_request, sampling
// config    cfg_we               cfg_index, cfg_data
//
// Each accepted word updates the state on the accepting edge, and its result
// appears in the output register on the next cycle.
// One word per cycle is sustained while out_ready is high; the single output
// register is the only buffer, so a stalled output holds off the input.
// Reset clears all state but the output data register and loads the default register values.

module sampled_toggle_switch_with_lockout #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       kind,
	input  wire logic                             switch_level,
	input  wire logic                             remote_value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  relay_on,
	output logic                                  locked,
	output logic                                  report_request,
	output logic                                  sampling,
	input  wire logic                             cfg_we,
	input  wire logic [stsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [stsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import stsw_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    step;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period_ms <= RST_SAMPLE_PERIOD;
			cfg_q.sample_count     <= RST_SAMPLE_COUNT;
			cfg_q.holdoff_ms       <= RST_HOLDOFF;
			cfg_q.press_limit      <= RST_PRESS_LIMIT;
			cfg_q.window_ms        <= RST_WINDOW;
			cfg_q.block_ms         <= RST_BLOCK;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_PERIOD: cfg_q.sample_period_ms <= cfg_data[7:0];
				REG_SAMPLE_COUNT:  cfg_q.sample_count     <= cfg_data[7:0];
				REG_HOLDOFF:       cfg_q.holdoff_ms       <= cfg_data;
				REG_PRESS_LIMIT:   cfg_q.press_limit      <= cfg_data[7:0];
				REG_WINDOW:        cfg_q.window_ms        <= cfg_data;
				REG_BLOCK:         cfg_q.block_ms         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	stsw_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.kind        (kind),
		.switch_level(switch_level),
		.remote_value(remote_value),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign relay_on       = res_q.relay_on;
	assign locked         = res_q.locked;
	assign report_request = res_q.report_request;
	assign sampling       = res_q.sampling;

endmodule

`default_nettype wire

FILE: hdl/stsw_core.sv
`default_nettype none

module stsw_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [1:0]       kind,
	input  wire logic             switch_level,
	input  wire logic             remote_value,
	input  wire stsw_pkg::cfg_t   cfg,
	output stsw_pkg::result_t     res
);
	import stsw_pkg::*;

	localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	function automatic logic [7:0] sat8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [TIMER_WIDTH-1:0] sat_tmr(input logic [TIMER_WIDTH-1:0] v);
		return (v == '1) ? v : v + TIMER_WIDTH'(1);
	endfunction

	logic                   burst_q, burst_n;
	logic [7:0]             period_q, period_n;
	logic [7:0]             low_hits_q, low_hits_n;
	logic [7:0]             samples_q, samples_n;
	logic [TIMER_WIDTH-1:0] since_q, since_n;
	logic                   relay_q, relay_n;
	logic                   win_open_q, win_open_n;
	logic [7:0]             toggles_q, toggles_n;
	logic [TIMER_WIDTH-1:0] win_el_q, win_el_n;
	logic                   lock_q, lock_n;
	logic [TIMER_WIDTH-1:0] lock_el_q, lock_el_n;
	logic                   rep;

	logic [7:0] period_inc;
	logic [7:0] low_inc;
	logic [7:0] samples_inc;
	logic [7:0] half;
	logic       hit;

	assign period_inc  = sat8(period_q);
	assign low_inc     = switch_level ? low_hits_q : sat8(low_hits_q);
	assign samples_inc = sat8(samples_q);
	assign half        = {1'b0, cfg.sample_count[7:1]};
	assign hit         = low_inc >= half;

	always_comb begin
		burst_n    = burst_q;
		period_n   = period_q;
		low_hits_n = low_hits_q;
		samples_n  = samples_q;
		since_n    = since_q;
		relay_n    = relay_q;
		win_open_n = win_open_q;
		toggles_n  = toggles_q;
		win_el_n   = win_el_q;
		lock_n     = lock_q;
		lock_el_n  = lock_el_q;
		rep        = 1'b0;
		unique case (kind_t'(kind))
			KIND_TICK: begin
				since_n = sat_tmr(since_q);
				if (win_open_q) begin
					win_el_n = sat_tmr(win_el_q);
				end
				if (lock_q) begin
					lock_el_n = sat_tmr(lock_el_q);
				end
				// Burst: sample once the period has run out.
				if (burst_q) begin
					if (period_inc < cfg.sample_period_ms) begin
						period_n = period_inc;
					end else begin
						period_n   = 8'd0;
						low_hits_n = low_inc;
						samples_n  = samples_inc;
						if (hit || samples_inc >= cfg.sample_count) begin
							if (hit && !lock_q) begin
								relay_n   = !relay_q;
								rep       = 1'b1;
								toggles_n = sat8(toggles_q);
							end
							burst_n    = 1'b0;
							low_hits_n = 8'd0;
							samples_n  = 8'd0;
							since_n    = '0;
						end
					end
				end
				// Lockout bookkeeping, in priority order.
				priority if (toggles_n != 8'd0 && !win_open_q) begin
					win_open_n = 1'b1;
					win_el_n   = '0;
				end else if (toggles_n >= cfg.press_limit) begin
					lock_n     = 1'b1;
					lock_el_n  = '0;
					toggles_n  = 8'd0;
					win_open_n = 1'b0;
				end else if (win_open_q && CW'(win_el_n) > CW'(cfg.window_ms)) begin
					toggles_n  = 8'd0;
					win_open_n = 1'b0;
				end else begin
				end
				if (lock_n && CW'(lock_el_n) > CW'(cfg.block_ms)) begin
					lock_n = 1'b0;
				end
			end
			KIND_EDGE: begin
				if (!burst_q && CW'(since_q) > CW'(cfg.holdoff_ms) && !lock_q) begin
					burst_n    = 1'b1;
					period_n   = 8'd0;
					low_hits_n = 8'd0;
					samples_n  = 8'd0;
				end
			end
			KIND_REMOTE: begin
				if (!lock_q) begin
					toggles_n = sat8(toggles_q);
					relay_n   = remote_value;
				end else begin
					rep = 1'b1;
				end
			end
			KIND_UNUSED: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q    <= 1'b0;
			period_q   <= 8'd0;
			low_hits_q <= 8'd0;
			samples_q  <= 8'd0;
			since_q    <= '0;
			relay_q    <= 1'b0;
			win_open_q <= 1'b0;
			toggles_q  <= 8'd0;
			win_el_q   <= '0;
			lock_q     <= 1'b0;
			lock_el_q  <= '0;
		end else if (step) begin
			burst_q    <= burst_n;
			period_q   <= period_n;
			low_hits_q <= low_hits_n;
			samples_q  <= samples_n;
			since_q    <= since_n;
			relay_q    <= relay_n;
			win_open_q <= win_open_n;
			toggles_q  <= toggles_n;
			win_el_q   <= win_el_n;
			lock_q     <= lock_n;
			lock_el_q  <= lock_el_n;
		end
	end

	assign res.relay_on       = relay_n;
	assign res.locked         = lock_n;
	assign res.report_request = rep;
	assign res.sampling       = burst_n;

endmodule

`default_nettype wire

FILE: hdl/stsw_checker.sv
`default_nettype none

module stsw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic relay_on,
	input wire logic locked,
	input wire logic report_request,
	input wire logic sampling
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output word dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(relay_on) && $stable(locked) && $stable(report_request) && $stable(sampling))
		else $error("Output word changed while stalled.");

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("Accepted word produced no result.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled with an empty output register.");

	a_report_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_request && !locked |-> !sampling)
		else $error("Toggle report while a burst is still running.");

endmodule

bind sampled_toggle_switch_with_lockout stsw_checker u_stsw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.relay_on      (relay_on),
	.locked        (locked),
	.report_request(report_request),
	.sampling      (sampling)
);

`default_nettype wire

FILE: tb/tb_sampled_toggle_switch_with_lockout.sv
`default_nettype none

module tb_sampled_toggle_switch_with_lockout;
	timeunit 1ns;
	timeprecision 1ps;

	import stsw_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 30;

	typedef enum logic {
		ROW_WORD,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t                 op;
		kind_t                   k;
		logic                    lvl;
		logic                    rv;
		logic                    chk;
		result_t                 res;
		logic [CFG_INDEX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]   val;
	} plan_row_t;

	// Result bits are relay_on, locked, report_request, sampling.
	localparam plan_row_t DIRECTED [30] = '{
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b1, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b1, 1'b0, 1'b1, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_UNUSED, 1'b1, 1'b1, 1'b1, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_EDGE,   1'b0, 1'b0, 1'b1, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_REMOTE, 1'b0, 1'b1, 1'b1, 4'b1000, '0, '0},
		'{ROW_WORD, KIND_REMOTE, 1'b1, 1'b0, 1'b1, 4'b0000, '0, '0},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_SAMPLE_PERIOD, 16'd0},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_SAMPLE_COUNT,  16'd1},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_HOLDOFF,       16'd0},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_PRESS_LIMIT,   16'd2},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_WINDOW,        16'd65535},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_BLOCK,         16'd1},
		'{ROW_WORD, KIND_EDGE,   1'b0, 1'b0, 1'b1, 4'b0001, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b1, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b1, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_REMOTE, 1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_EDGE,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_SAMPLE_PERIOD, 16'd2},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_SAMPLE_COUNT,  16'd4},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_PRESS_LIMIT,   16'd1},
		'{ROW_CFG,  KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, REG_BLOCK,         16'd65535},
		'{ROW_WORD, KIND_EDGE,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_REMOTE, 1'b0, 1'b1, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b0, 1'b0, 1'b0, 4'b0000, '0, '0},
		'{ROW_WORD, KIND_TICK,   1'b1, 1'b0, 1'b0, 4'b0000, '0, '0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             kind;
	logic                   switch_level;
	logic                   remote_value;
	logic                   out_valid;
	logic                   out_ready;
	logic                   relay_on;
	logic                   locked;
	logic                   report_request;
	logic                   sampling;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic    row_chk;
	result_t row_res;
	logic    long_hold_req;
	int      burst_left;
	int      words_sent;
	int      results_checked;
	int      report_pulses;
	int      lockouts;
	int      reg_writes;
	int      settings;
	int      fails;
	logic    last_locked;

	result_t pending_status[$];

	logic [7:0]  m_period, m_count, m_limit;
	logic [15:0] m_holdoff, m_window, m_block;
	logic        m_burst, m_relay, m_win_open, m_lock;
	logic [7:0]  m_ptimer, m_lows, m_samples, m_toggles;
	logic [15:0] m_since, m_win_el, m_lock_el;

	sampled_toggle_switch_with_lockout dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] inc8(logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [15:0] inc16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic result_t advance_switch(kind_t k, logic lvl, logic rv);
		logic       rep;
		logic [7:0] half;
		result_t    r;
		rep = 1'b0;
		case (k)
			KIND_TICK: begin
				m_since = inc16(m_since);
				if (m_win_open)
					m_win_el = inc16(m_win_el);
				if (m_lock)
					m_lock_el = inc16(m_lock_el);
				if (m_burst) begin
					m_ptimer = inc8(m_ptimer);
					if (m_ptimer >= m_period) begin
						m_ptimer = '0;
						if (!lvl)
							m_lows = inc8(m_lows);
						m_samples = inc8(m_samples);
						half = m_count >> 1;
						if (m_lows >= half || m_samples >= m_count) begin
							if (m_lows >= half && !m_lock) begin
								m_relay = !m_relay;
								rep = 1'b1;
								m_toggles = inc8(m_toggles);
							end
							m_burst = 1'b0;
							m_lows = '0;
							m_samples = '0;
							m_since = '0;
						end
					end
				end
				if (m_toggles != 8'd0 && !m_win_open) begin
					m_win_open = 1'b1;
					m_win_el = '0;
				end else if (m_toggles >= m_limit) begin
					m_lock = 1'b1;
					m_lock_el = '0;
					m_toggles = '0;
					m_win_open = 1'b0;
				end else if (m_win_open && m_win_el > m_window) begin
					m_toggles = '0;
					m_win_open = 1'b0;
				end
				if (m_lock && m_lock_el > m_block)
					m_lock = 1'b0;
			end
			KIND_EDGE: begin
				if (!m_burst && m_since > m_holdoff && !m_lock) begin
					m_burst = 1'b1;
					m_ptimer = '0;
					m_lows = '0;
					m_samples = '0;
				end
			end
			KIND_REMOTE: begin
				if (!m_lock) begin
					m_toggles = inc8(m_toggles);
					m_relay = rv;
				end else begin
					rep = 1'b1;
				end
			end
			default: ;
		endcase
		r.relay_on = m_relay;
		r.locked = m_lock;
		r.report_request = rep;
		r.sampling = m_burst;
		return r;
	endfunction

	task automatic check_bit(input string what, input logic want, input logic got);
		if (want !== got) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %b, got %b", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : status_check
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_period = RST_SAMPLE_PERIOD;
			m_count = RST_SAMPLE_COUNT;
			m_holdoff = RST_HOLDOFF;
			m_limit = RST_PRESS_LIMIT;
			m_window = RST_WINDOW;
			m_block = RST_BLOCK;
			m_burst = 1'b0;
			m_relay = 1'b0;
			m_win_open = 1'b0;
			m_lock = 1'b0;
			m_ptimer = '0;
			m_lows = '0;
			m_samples = '0;
			m_toggles = '0;
			m_since = '0;
			m_win_el = '0;
			m_lock_el = '0;
			last_locked = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {relay_on, locked, report_request, sampling};
				if (pending_status.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: word %b arrived with nothing expected", $time, got);
				end else begin
					want = pending_status.pop_front();
					check_bit("relay_on", want.relay_on, got.relay_on);
					check_bit("locked", want.locked, got.locked);
					check_bit("report_request", want.report_request, got.report_request);
					check_bit("sampling", want.sampling, got.sampling);
					results_checked++;
				end
				if (got.report_request)
					report_pulses++;
				if (got.locked && !last_locked)
					lockouts++;
				last_locked = got.locked;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_PERIOD: m_period = cfg_data[7:0];
					REG_SAMPLE_COUNT:  m_count = cfg_data[7:0];
					REG_HOLDOFF:       m_holdoff = cfg_data;
					REG_PRESS_LIMIT:   m_limit = cfg_data[7:0];
					REG_WINDOW:        m_window = cfg_data;
					REG_BLOCK:         m_block = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = advance_switch(kind_t'(kind), switch_level, remote_value);
				pending_status.push_back(row_chk ? row_res : want);
			end
		end
	end

	initial begin : receiver
		int rx_mode;
		int rx_count;
		rx_mode = 0;
		rx_count = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end
			rx_count++;
			if (rx_count % 80 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 4) != 0);
				default: out_ready <= (rx_count % 5 > 1);
			endcase
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("no completion after %0d cycles", cycles);
		$display("status: fail");
		$finish;
	end

	task automatic send_word(input kind_t k, input logic lvl, input logic rv,
			input logic chk, input result_t res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		switch_level <= lvl;
		remote_value <= rv;
		row_chk <= chk;
		row_res <= res;
		if (k != KIND_UNUSED)
			words_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// A press is an edge followed by ticks whose level is mostly low or mostly
	// high; the rest is remote commands, idle ticks and random noise words.
	task automatic run_phase(input logic [7:0] sp, input logic [7:0] sc,
			input logic [15:0] ho, input logic [7:0] pl, input logic [15:0] wi,
			input logic [15:0] bl, input int n_items, input int press_cap,
			input int remote_pct, input logic hold);
		int start;
		int pick;
		int n;
		int low_pct;
		settle_block();
		write_reg(REG_SAMPLE_PERIOD, {8'd0, sp});
		write_reg(REG_SAMPLE_COUNT, {8'd0, sc});
		write_reg(REG_HOLDOFF, ho);
		write_reg(REG_PRESS_LIMIT, {8'd0, pl});
		write_reg(REG_WINDOW, wi);
		write_reg(REG_BLOCK, bl);
		settings++;
		if (hold)
			long_hold_req = 1'b1;
		if (remote_pct >= 90)
			repeat (260) send_word(KIND_REMOTE, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b0, '0);
		start = words_sent;
		while (words_sent - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < remote_pct) begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(KIND_REMOTE, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					low_pct = ($urandom_range(0, 2) == 0) ? 20 : 85;
					send_word(KIND_EDGE, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'b0, '0);
					n = $urandom_range(1, press_cap);
					repeat (n) send_word(KIND_TICK,
						($urandom_range(0, 99) >= low_pct), 1'($urandom_range(0, 1)),
						1'b0, '0);
				end else if (pick < 85) begin
					n = $urandom_range(1, 40);
					repeat (n) send_word(KIND_TICK, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'b0, '0);
				end else begin
					n = $urandom_range(1, 4);
					repeat (n) send_word(kind_t'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
				end
			end
		end
	endtask

	initial begin : stimulus
		int p;
		logic [7:0] sp, sc;
		int cap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		switch_level = 1'b0;
		remote_value = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		row_chk = 1'b0;
		row_res = '0;
		long_hold_req = 1'b0;
		burst_left = 0;
		words_sent = 0;
		results_checked = 0;
		report_pulses = 0;
		lockouts = 0;
		reg_writes = 0;
		settings = 0;
		fails = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].op == ROW_CFG) begin
				settle_block();
				write_reg(DIRECTED[i].idx, DIRECTED[i].val);
			end else begin
				send_word(DIRECTED[i].k, DIRECTED[i].lvl, DIRECTED[i].rv,
					DIRECTED[i].chk, DIRECTED[i].res);
			end
		end

		run_phase(8'd1, 8'd2, 16'd0, 8'd1, 16'd1, 16'd1, 80, 8, 10, 1'b1);
		for (p = 0; p < 5; p++) begin
			sp = 8'($urandom_range(0, 3));
			sc = 8'($urandom_range(0, 8));
			cap = sc * (sp + 1) + 4;
			run_phase(sp, sc, 16'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
				16'($urandom_range(0, 50)), 16'($urandom_range(0, 30)), 50, cap, 10, 1'b0);
		end
		run_phase(8'd255, 8'd255, 16'd65535, 8'd255, 16'd65535, 16'd65535, 40, 4, 95,
			1'b0);
		run_phase(8'd0, 8'd255, 16'd1, 8'd255, 16'd65535, 16'd1, 100, 300, 5, 1'b0);
		run_phase(RST_SAMPLE_PERIOD, RST_SAMPLE_COUNT, RST_HOLDOFF, RST_PRESS_LIMIT,
			RST_WINDOW, RST_BLOCK, 60, 220, 10, 1'b0);

		settle_block();
		repeat (4) @(posedge clk);
		$display("covered %0d words and %0d checked results, with %0d report pulses",
			words_sent, results_checked, report_pulses);
		$display("and %0d lockouts over %0d register writes in %0d settings",
			lockouts, reg_writes, settings);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", fails);
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sampled_toggle_switch_with_lockout.f
hdl/stsw_pkg.sv
hdl/stsw_core.sv
hdl/sampled_toggle_switch_with_lockout.sv
hdl/stsw_checker.sv
tb/tb_sampled_toggle_switch_with_lockout.sv
